/* rtl/core/assert_macros.svh */
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gfmi_pkg.sv */
package gfmi_pkg;

  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 4;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int FIELD_SIZE = 256;
  localparam logic [8:0] GF_POLY   = 9'h11D;
  localparam logic [8:0] GF_ORDER  = 9'd255;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // register index taken from paddr above the byte lanes
  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

  typedef logic [FIELD_SIZE-1:0][BYTE_W-1:0] gf_tbl_t;

  function automatic gf_tbl_t gen_alog();
    gf_tbl_t    t;
    logic [8:0] v;
    v = 9'd1;
    for (int i = 0; i < FIELD_SIZE; i++) begin
      t[i] = v[7:0];
      v = {v[7:0], 1'b0};
      if (v[8]) v = v ^ GF_POLY;
    end
    return t;
  endfunction

  function automatic gf_tbl_t gen_log();
    gf_tbl_t    t;
    logic [8:0] v;
    t = '0;
    v = 9'd1;
    for (int i = 0; i < FIELD_SIZE; i++) begin
      t[v[7:0]] = 8'(i);
      v = {v[7:0], 1'b0};
      if (v[8]) v = v ^ GF_POLY;
    end
    t[1] = 8'd0;
    return t;
  endfunction

  localparam gf_tbl_t ALOG = gen_alog();
  localparam gf_tbl_t LOG  = gen_log();

  // exponent sum mod 255, both inputs below 255
  function automatic logic [7:0] log_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= GF_ORDER) s = s - GF_ORDER;
    return s[7:0];
  endfunction

  // exponent difference mod 255
  function automatic logic [7:0] log_sub(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + GF_ORDER - {1'b0, b};
    if (s >= GF_ORDER) s = s - GF_ORDER;
    return s[7:0];
  endfunction

endpackage

/* rtl/core/gfmi_ram.sv */
module gfmi_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] ra_addr,
  output logic [WIDTH-1:0]  ra_data,
  input  logic [ADDR_W-1:0] rb_addr,
  output logic [WIDTH-1:0]  rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

/* rtl/core/gf256_matrix_inverse.sv */
// Inverts an N by N matrix over GF(2^8), field polynomial 0x11D.
// Input channel: a beat is taken when start is high and busy is low; each
// beat carries one matrix byte in row-major order, one beat per cycle.
// After the N*N-th byte, busy stays high while Gauss-Jordan elimination
// runs on [A|I] held in one memory whose rows are 2*MAX_ORDER bytes,
// rounded up to a power of two. Every row operation streams 2N columns
// through a read, multiply and write-back pipe and drains it before the
// next operation reads. A zero pivot is repaired by adding a lower row
// that is nonzero in that column.
// Results: N*N beats on out_strobe, one per cycle, row-major, out_last on
// the final one; busy drops in the cycle the final beat shows. A singular
// matrix gives zero values with out_singular high on every beat. The
// receiver cannot hold results off.
// Config: matrix_size at byte address 0 (APB, pready always high), to be
// written by the user only while idle; the block does not enforce this. Writing
// it restarts loading. 0 acts as 1, values above MAX_ORDER act as MAX_ORDER.
// Reset: load position cleared, matrix_size back to 8, no beat pending.
module gf256_matrix_inverse #(
  parameter int MAX_ORDER = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gfmi_pkg::BYTE_W-1:0]   in_element_value,
  output logic                          out_strobe,
  output logic [gfmi_pkg::BYTE_W-1:0]   out_inverse_value,
  output logic                          out_last,
  output logic                          out_singular,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gfmi_pkg::CFG_AW-1:0]   paddr,
  input  logic [gfmi_pkg::CFG_DW-1:0]   pwdata,
  output logic [gfmi_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  import gfmi_pkg::*;

  localparam int RW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW    = $clog2(2 * MAX_ORDER);
  localparam int N_W   = $clog2(MAX_ORDER + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [3:0] {
    S_IDLE, S_IDENT, S_PIV_RD, S_PIV_CHK, S_SRCH_RD, S_SRCH_CHK,
    S_ELIM_RD, S_ELIM_CHK, S_SCALE, S_ROW, S_NEXT, S_OUT
  } state_t;

  state_t state_r, ret_r;

  logic [SIZE_W-1:0] size_r;
  logic [N_W-1:0]    n_eff, n_m1;
  logic [CW-1:0]     last_col;

  logic [N_W-1:0] ld_row_r, ld_col_r;
  logic [N_W-1:0] i_r, k_r, oc_r;
  logic [RW-1:0]  dst_r, src_r;
  logic           xor_r, repaired_r, sing_r;
  logic [7:0]     flog_r, piv_log_r;

  logic          iss_act_r, p1_vld_r, p2_vld_r, p2_zero_r;
  logic [CW-1:0] iss_c_r, p1_col_r, p2_col_r;
  logic [7:0]    p2_base_r, p2_exp_r;

  logic out_vld_r, out_last_r;

  logic                  we;
  logic [AW-1:0]         waddr, ra_addr, rb_addr;
  logic [BYTE_W-1:0]     wdata, ra_data, rb_data, prod;
  logic                  accept, cfg_wr;

  always_comb begin
    if (size_r == '0) n_eff = N_W'(1);
    else if (int'(size_r) > MAX_ORDER) n_eff = N_W'(MAX_ORDER);
    else n_eff = N_W'(size_r);
  end

  assign n_m1     = n_eff - 1'b1;
  assign last_col = CW'({n_eff, 1'b0} - 1'b1);

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_AW-1:2] == REG_MATRIX_SIZE) ?
                  {{(CFG_DW - SIZE_W){1'b0}}, size_r} : '0;

  assign prod = p2_zero_r ? '0 : ALOG[p2_exp_r];

  // write port: load, identity fill, or row pipe write-back
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state_r)
      S_IDLE: begin
        we    = accept;
        waddr = {ld_row_r[RW-1:0], CW'(ld_col_r)};
        wdata = in_element_value;
      end
      S_IDENT: begin
        we    = 1'b1;
        waddr = {k_r[RW-1:0], CW'(n_eff) + CW'(oc_r)};
        wdata = (k_r == oc_r) ? BYTE_W'(1) : '0;
      end
      S_ROW: begin
        we    = p2_vld_r;
        waddr = {dst_r, p2_col_r};
        wdata = p2_base_r ^ prod;
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    case (state_r)
      S_PIV_RD:             ra_addr = {i_r[RW-1:0], CW'(i_r)};
      S_SRCH_RD, S_ELIM_RD: ra_addr = {k_r[RW-1:0], CW'(i_r)};
      S_ROW:                ra_addr = {dst_r, iss_c_r};
      S_OUT:                ra_addr = {k_r[RW-1:0], CW'(n_eff) + CW'(oc_r)};
      default:              ra_addr = '0;
    endcase
  end

  assign rb_addr = {src_r, iss_c_r};

  gfmi_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .ra_addr(ra_addr),
    .ra_data(ra_data),
    .rb_addr(rb_addr),
    .rb_data(rb_data)
  );

  always_ff @(posedge clk) begin
    // row pipe payload
    p1_col_r  <= iss_c_r;
    p2_col_r  <= p1_col_r;
    p2_base_r <= xor_r ? ra_data : '0;
    p2_zero_r <= (rb_data == '0);
    p2_exp_r  <= log_add(LOG[rb_data], flog_r);

    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      size_r     <= SIZE_RESET;
      ld_row_r   <= '0;
      ld_col_r   <= '0;
      iss_act_r  <= 1'b0;
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
      sing_r     <= 1'b0;
      repaired_r <= 1'b0;
    end else begin
      out_vld_r <= 1'b0;
      p1_vld_r  <= (state_r == S_ROW) && iss_act_r;
      p2_vld_r  <= p1_vld_r;

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (ld_col_r == n_m1) begin
              ld_col_r <= '0;
              if (ld_row_r == n_m1) begin
                ld_row_r <= '0;
                k_r      <= '0;
                oc_r     <= '0;
                sing_r   <= 1'b0;
                state_r  <= S_IDENT;
              end else begin
                ld_row_r <= ld_row_r + 1'b1;
              end
            end else begin
              ld_col_r <= ld_col_r + 1'b1;
            end
          end
        end
        S_IDENT: begin
          if (oc_r == n_m1) begin
            oc_r <= '0;
            if (k_r == n_m1) begin
              i_r        <= '0;
              repaired_r <= 1'b0;
              state_r    <= S_PIV_RD;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else begin
            oc_r <= oc_r + 1'b1;
          end
        end
        S_PIV_RD: state_r <= S_PIV_CHK;
        S_PIV_CHK: begin
          piv_log_r <= LOG[ra_data];
          if (ra_data != '0) begin
            k_r     <= '0;
            state_r <= S_ELIM_RD;
          end else if (repaired_r) begin
            sing_r  <= 1'b1;
            k_r     <= '0;
            oc_r    <= '0;
            state_r <= S_OUT;
          end else begin
            k_r     <= i_r + 1'b1;
            state_r <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: begin
          if (k_r == n_eff) begin
            // no lower row can repair the pivot
            sing_r  <= 1'b1;
            k_r     <= '0;
            oc_r    <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_SRCH_CHK;
          end
        end
        S_SRCH_CHK: begin
          if (ra_data != '0) begin
            flog_r     <= log_sub(8'd0, LOG[ra_data]);
            dst_r      <= i_r[RW-1:0];
            src_r      <= k_r[RW-1:0];
            xor_r      <= 1'b1;
            ret_r      <= S_PIV_RD;
            repaired_r <= 1'b1;
            iss_act_r  <= 1'b1;
            iss_c_r    <= '0;
            state_r    <= S_ROW;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SRCH_RD;
          end
        end
        S_ELIM_RD: begin
          if (k_r == n_eff) state_r <= S_SCALE;
          else if (k_r == i_r) k_r <= k_r + 1'b1;
          else state_r <= S_ELIM_CHK;
        end
        S_ELIM_CHK: begin
          k_r <= k_r + 1'b1;
          if (ra_data != '0) begin
            flog_r    <= log_sub(LOG[ra_data], piv_log_r);
            dst_r     <= k_r[RW-1:0];
            src_r     <= i_r[RW-1:0];
            xor_r     <= 1'b1;
            ret_r     <= S_ELIM_RD;
            iss_act_r <= 1'b1;
            iss_c_r   <= '0;
            state_r   <= S_ROW;
          end else begin
            state_r <= S_ELIM_RD;
          end
        end
        S_SCALE: begin
          // multiply the pivot row by the pivot's inverse
          flog_r    <= log_sub(8'd0, piv_log_r);
          dst_r     <= i_r[RW-1:0];
          src_r     <= i_r[RW-1:0];
          xor_r     <= 1'b0;
          ret_r     <= S_NEXT;
          iss_act_r <= 1'b1;
          iss_c_r   <= '0;
          state_r   <= S_ROW;
        end
        S_ROW: begin
          if (iss_act_r) begin
            if (iss_c_r == last_col) iss_act_r <= 1'b0;
            else iss_c_r <= iss_c_r + 1'b1;
          end else if (!p1_vld_r && !p2_vld_r) begin
            // pipe drained, next reads see every write-back
            state_r <= ret_r;
          end
        end
        S_NEXT: begin
          if (i_r == n_m1) begin
            k_r     <= '0;
            oc_r    <= '0;
            state_r <= S_OUT;
          end else begin
            i_r        <= i_r + 1'b1;
            repaired_r <= 1'b0;
            state_r    <= S_PIV_RD;
          end
        end
        S_OUT: begin
          out_vld_r  <= 1'b1;
          out_last_r <= (k_r == n_m1) && (oc_r == n_m1);
          if (oc_r == n_m1) begin
            oc_r <= '0;
            if (k_r == n_m1) state_r <= S_IDLE;
            else k_r <= k_r + 1'b1;
          end else begin
            oc_r <= oc_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      if (cfg_wr && paddr[CFG_AW-1:2] == REG_MATRIX_SIZE) begin
        size_r   <= pwdata[SIZE_W-1:0];
        ld_row_r <= '0;
        ld_col_r <= '0;
      end
    end
  end

  // read data arrives in the cycle after the issue in S_OUT
  assign out_strobe        = out_vld_r;
  assign out_inverse_value = sing_r ? '0 : ra_data;
  assign out_last          = out_last_r;
  assign out_singular      = sing_r;

endmodule

/* rtl/core/gfmi_check.sv */
`include "assert_macros.svh"

module gfmi_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [gfmi_pkg::BYTE_W-1:0]   out_inverse_value,
  input logic                          out_last,
  input logic                          out_singular
);

  // only the final result beat may show while the block is idle
  `CHK_SAME(a_idle_beat_last, out_strobe && !busy, out_last, "result beat while idle")
  // a singular matrix reads out as zeros
  `CHK_SAME(a_sing_zero, out_strobe && out_singular, out_inverse_value == 8'd0, "nonzero singular")
  // the final beat closes the burst
  `CHK_NEXT(a_last_ends, out_strobe && out_last, !out_strobe, "beat after last")
  // no result beat right after a load byte is taken
  `CHK_NEXT(a_load_quiet, start && !busy, !out_strobe, "result beat during load")

endmodule

bind gf256_matrix_inverse gfmi_check u_gfmi_check (.*);

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER    = 8;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 2000;
  localparam int RANDOM_ITEMS = 320;
  localparam int AW           = gfmi_pkg::CFG_AW;
  localparam int DW           = gfmi_pkg::CFG_DW;
  localparam logic [7:0]    POLY_LOW         = 8'h1D;
  localparam logic [0:0]    REG_SPARE        = 1'b1;
  localparam logic [AW-1:0] ADDR_MATRIX_SIZE = {gfmi_pkg::REG_MATRIX_SIZE, 2'b00};
  localparam logic [AW-1:0] ADDR_SPARE       = {REG_SPARE, 2'b00};

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       sing;
  } inverse_beat_t;

  typedef struct packed {
    logic [3:0]       size;
    logic [4:0]       count;
    logic [0:3][7:0]  elem;
    logic             typed;
    logic [0:3][7:0]  want;
    logic             want_sing;
    logic             junk;
  } opening_row_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [7:0]    in_element_value;
  logic          out_strobe;
  logic [7:0]    out_inverse_value;
  logic          out_last;
  logic          out_singular;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  gf256_matrix_inverse #(.MAX_ORDER(MAX_ORDER)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_element_value  (in_element_value),
    .out_strobe        (out_strobe),
    .out_inverse_value (out_inverse_value),
    .out_last          (out_last),
    .out_singular      (out_singular),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [7:0]    aug [MAX_ORDER][2*MAX_ORDER];
  logic [3:0]    size_reg;
  int            load_pos;
  inverse_beat_t pending_inverse[$];
  inverse_beat_t fresh_beats[$];

  logic [7:0]    draft [MAX_ORDER][MAX_ORDER];
  opening_row_t  opening_rows [8];
  int            fail_count;
  int            sent_count;
  int            burst_left;
  int            quiet_cycles;
  bit            steady;

  function automatic void note_failure(input string what, input logic [31:0] exp_v,
                                       input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = x[7] ? ((x << 1) ^ POLY_LOW) : (x << 1);
    end
    return p;
  endfunction

  function automatic logic [7:0] gf_recip(input logic [7:0] b);
    for (int v = 1; v < 256; v++)
      if (gf_prod(b, 8'(v)) == 8'h01) return 8'(v);
    return 8'h00;
  endfunction

  function automatic int order_of(input logic [3:0] s);
    if (s == 4'd0) return 1;
    if (s > 4'(MAX_ORDER)) return MAX_ORDER;
    return int'(s);
  endfunction

  // gauss-jordan on [A|I], returns 1 when no usable pivot
  function automatic bit eliminate(input int n);
    logic [7:0] f;
    bit         done;
    for (int i = 0; i < n; i++)
      for (int c = 0; c < n; c++)
        aug[i][n+c] = (i == c) ? 8'h01 : 8'h00;
    for (int i = 0; i < n; i++) begin
      if (aug[i][i] == 8'h00) begin
        done = 1'b0;
        for (int k = i + 1; k < n; k++) begin
          if (!done && aug[k][i] != 8'h00) begin
            f = gf_recip(aug[k][i]);
            for (int c = 0; c < 2*n; c++)
              aug[i][c] = aug[i][c] ^ gf_prod(aug[k][c], f);
            done = 1'b1;
          end
        end
      end
      if (aug[i][i] == 8'h00) return 1'b1;
      for (int k = 0; k < n; k++) begin
        if (k != i && aug[k][i] != 8'h00) begin
          f = gf_prod(aug[k][i], gf_recip(aug[i][i]));
          for (int c = 0; c < 2*n; c++)
            aug[k][c] = aug[k][c] ^ gf_prod(aug[i][c], f);
        end
      end
      f = gf_recip(aug[i][i]);
      for (int c = 0; c < 2*n; c++)
        aug[i][c] = gf_prod(aug[i][c], f);
    end
    return 1'b0;
  endfunction

  function automatic void absorb_element(input logic [7:0] b);
    int n;
    int total;
    bit sing;
    n = order_of(size_reg);
    total = n * n;
    fresh_beats.delete();
    if (load_pos >= total) load_pos = 0;
    aug[load_pos / n][load_pos % n] = b;
    load_pos++;
    if (load_pos < total) return;
    load_pos = 0;
    sing = eliminate(n);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        fresh_beats.push_back('{value: sing ? 8'h00 : aug[r][n+c],
                                last: (r * n + c == total - 1), sing: sing});
  endfunction

  function automatic void build_draft(input int n, input int pick);
    int         perm [MAX_ORDER];
    int         a;
    int         b;
    int         j;
    int         t;
    logic [7:0] scale;
    logic [7:0] corner [4];
    corner = '{8'h00, 8'h01, 8'h80, 8'hFF};
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        draft[r][c] = 8'($urandom_range(0, 255));
    if (pick >= 30 && pick < 50) begin
      // sparse, lots of zero pivots and rank loss
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          draft[r][c] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    end else if (pick >= 50 && pick < 70) begin
      // scaled permutation, often needs the lower-row pivot fix
      for (int i = 0; i < n; i++) perm[i] = i;
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = perm[i];
        perm[i] = perm[j];
        perm[j] = t;
      end
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          draft[r][c] = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      for (int r = 0; r < n; r++) draft[r][perm[r]] = 8'($urandom_range(1, 255));
    end else if (pick >= 70 && pick < 85) begin
      // one row a multiple of another
      if (n == 1) begin
        draft[0][0] = 8'h00;
      end else begin
        a = $urandom_range(0, n - 1);
        b = (a + $urandom_range(1, n - 1)) % n;
        scale = 8'($urandom_range(0, 255));
        for (int c = 0; c < n; c++) draft[b][c] = gf_prod(draft[a][c], scale);
      end
    end else if (pick >= 85) begin
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++)
          draft[r][c] = corner[$urandom_range(0, 3)];
    end
  endfunction

  task automatic pace_sender();
    int gap;
    if (steady) return;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_element(input logic [7:0] b, input bit typed,
                              input logic [0:3][7:0] want, input logic want_sing);
    pace_sender();
    @(negedge clk);
    start <= 1'b1;
    in_element_value <= b;
    do @(posedge clk); while (busy);
    absorb_element(b);
    for (int k = 0; k < fresh_beats.size(); k++) begin
      if (typed)
        pending_inverse.push_back('{value: want[k], last: (k == fresh_beats.size() - 1),
                                    sing: want_sing});
      else
        pending_inverse.push_back(fresh_beats[k]);
    end
    sent_count++;
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk);
    start <= 1'b0;
    while (pending_inverse.size() != 0 || busy) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [AW-1:0] addr, input logic [DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[AW-1:2] == gfmi_pkg::REG_MATRIX_SIZE) begin
      size_reg = data[3:0];
      load_pos = 0;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read(input logic [AW-1:0] addr, output logic [DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_matrix_size(input logic [3:0] sz);
    logic [DW-1:0] rd;
    cfg_write(ADDR_MATRIX_SIZE, DW'(sz));
    cfg_read(ADDR_MATRIX_SIZE, rd);
    if (rd !== DW'(size_reg)) note_failure("matrix_size readback", DW'(size_reg), rd);
  endtask

  // result side: cannot stall, every strobe is a beat
  always @(posedge clk) begin
    inverse_beat_t want;
    if (rst_n && out_strobe) begin
      if (pending_inverse.size() == 0) begin
        note_failure("beat with nothing pending", 32'h0, {24'h0, out_inverse_value});
      end else begin
        want = pending_inverse.pop_front();
        if (out_inverse_value !== want.value)
          note_failure("inverse_value", 32'(want.value), 32'(out_inverse_value));
        if (out_last !== want.last)
          note_failure("last", 32'(want.last), 32'(out_last));
        if (out_singular !== want.sing)
          note_failure("singular", 32'(want.sing), 32'(out_singular));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    opening_row_t  row;
    logic [DW-1:0] rd;
    logic [3:0]    sz;
    int            n;
    int            total;
    int            cut;
    int            mcount;
    int            phase;
    int            pick;

    rst_n = 1'b0;
    start = 1'b0;
    in_element_value = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    size_reg = 4'd8;
    load_pos = 0;
    fail_count = 0;
    sent_count = 0;
    burst_left = 0;
    quiet_cycles = 0;
    steady = 1'b0;

    opening_rows[0] = '{size: 4'd1, count: 5'd1, elem: {8'h01, 24'h0}, typed: 1'b1,
                        want: {8'h01, 24'h0}, want_sing: 1'b0, junk: 1'b0};
    opening_rows[1] = '{size: 4'd1, count: 5'd1, elem: 32'h0, typed: 1'b1,
                        want: 32'h0, want_sing: 1'b1, junk: 1'b0};
    // size zero behaves as order one
    opening_rows[2] = '{size: 4'd0, count: 5'd1, elem: {8'hFF, 24'h0}, typed: 1'b0,
                        want: 32'h0, want_sing: 1'b0, junk: 1'b0};
    // spare register poked mid-load must not disturb the load
    opening_rows[3] = '{size: 4'd2, count: 5'd4, elem: 32'h01000001, typed: 1'b1,
                        want: 32'h01000001, want_sing: 1'b0, junk: 1'b1};
    opening_rows[4] = '{size: 4'd2, count: 5'd4, elem: 32'h00010100, typed: 1'b1,
                        want: 32'h00010100, want_sing: 1'b0, junk: 1'b0};
    opening_rows[5] = '{size: 4'd2, count: 5'd4, elem: 32'h01010101, typed: 1'b1,
                        want: 32'h0, want_sing: 1'b1, junk: 1'b0};
    // partial load, the next size write restarts it
    opening_rows[6] = '{size: 4'd2, count: 5'd3, elem: 32'h12345600, typed: 1'b0,
                        want: 32'h0, want_sing: 1'b0, junk: 1'b0};
    opening_rows[7] = '{size: 4'd2, count: 5'd4, elem: 32'h80FF0002, typed: 1'b0,
                        want: 32'h0, want_sing: 1'b0, junk: 1'b0};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_read(ADDR_MATRIX_SIZE, rd);
    if (rd !== DW'(gfmi_pkg::SIZE_RESET))
      note_failure("matrix_size after reset", DW'(gfmi_pkg::SIZE_RESET), rd);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      wait_drained(4);
      set_matrix_size(row.size);
      for (int j = 0; j < row.count; j++) begin
        if (row.junk && j == 2) begin
          wait_drained(0);
          cfg_write(ADDR_SPARE, 32'hFFFF_FFFF);
        end
        send_element(row.elem[j], row.typed, row.want, row.want_sing);
      end
    end

    sent_count = 0;
    phase = 0;
    while (sent_count < RANDOM_ITEMS) begin
      wait_drained(4);
      case (phase)
        0: sz = 4'd8;
        1: sz = 4'd15;
        2: sz = 4'd0;
        3: sz = 4'd1;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 12)      sz = 4'($urandom_range(1, 4));
          else if (pick < 17) sz = 4'($urandom_range(5, 8));
          else if (pick == 17) sz = 4'd0;
          else                sz = 4'($urandom_range(9, 15));
        end
      endcase
      set_matrix_size(sz);
      if ($urandom_range(0, 5) == 0) cfg_write(ADDR_SPARE, DW'($urandom()));
      steady = ($urandom_range(0, 3) == 0);
      n = order_of(sz);
      total = n * n;
      mcount = $urandom_range(1, 3);
      for (int m = 0; m < mcount; m++) begin
        if (m > 0 && $urandom_range(0, 3) == 0) wait_drained(0);
        build_draft(n, $urandom_range(0, 99));
        cut = total;
        if (total > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, total - 1);
        for (int j = 0; j < cut; j++)
          send_element(draft[j / n][j % n], 1'b0, '0, 1'b0);
        if (cut < total) break;
      end
      phase++;
    end

    wait_drained(0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_inverse.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
